// ===== sv/sfbc_pkg.sv =====
// Shared types and constants for the Alamouti SFBC pilot encoder.
package sfbc_pkg;

    localparam int POS_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W     = 8;
    localparam int MASK_W    = 64;
    localparam int MASK_IDX_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_PAIRS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_HI = 2'd2;

    localparam logic [LEN_W-1:0] PAIRS_RESET = 8'd32;

    // sqrt(2) in Q2.14, rounding offset and shift
    localparam int COEF_W      = 17;
    localparam int SQRT2_Q14   = 23170;
    localparam int ROUND_HALF  = 8192;
    localparam int SCALE_SHIFT = 14;

    typedef struct packed {
        logic pilot;
        logic last;
    } pair_flags_t;

endpackage

// ===== sv/sfbc_ctrl.sv =====
// Configuration registers, pair position counter and pilot lookup.
module sfbc_ctrl import sfbc_pkg::*; #(
    parameter int MAX_PAIRS = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  advance,
    output pair_flags_t           flags
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAIRS);

    logic [LEN_W-1:0]  pairs_reg;
    logic [MASK_W-1:0] mask_lo_reg;
    logic [MASK_W-1:0] mask_hi_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [LEN_W-1:0]  len_eff;
    logic [LEN_W-1:0]  pos_inc;

    always_comb
    begin
        if (pairs_reg == '0 || pairs_reg > MAX_LEN)
        begin
            len_eff = MAX_LEN;
        end
        else
        begin
            len_eff = pairs_reg;
        end
        pos_inc     = LEN_W'(pos_reg) + LEN_W'(1);
        flags.last  = (pos_inc >= len_eff);
        flags.pilot = pos_reg[POS_W-1] ? mask_hi_reg[pos_reg[MASK_IDX_W-1:0]]
                                       : mask_lo_reg[pos_reg[MASK_IDX_W-1:0]];
        pos_next    = flags.last ? '0 : pos_inc[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs_reg   <= PAIRS_RESET;
            mask_lo_reg <= '0;
            mask_hi_reg <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    CFG_PAIRS:   pairs_reg   <= cfg_data[LEN_W-1:0];
                    CFG_MASK_LO: mask_lo_reg <= cfg_data;
                    CFG_MASK_HI: mask_hi_reg <= cfg_data;
                    default:     ;
                endcase
            end
            if (advance)
            begin
                pos_reg <= pos_next;
            end
        end
    end

endmodule

// ===== sv/sfbc_encode.sv =====
// Alamouti pair mapping with sqrt(2) pilot boost and output saturation.
module sfbc_encode import sfbc_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic signed [SAMPLE_BITS-1:0] first_re,
    input  logic signed [SAMPLE_BITS-1:0] first_im,
    input  logic signed [SAMPLE_BITS-1:0] second_re,
    input  logic signed [SAMPLE_BITS-1:0] second_im,
    input  logic                          pilot,
    output logic signed [SAMPLE_BITS-1:0] ant1_first_re,
    output logic signed [SAMPLE_BITS-1:0] ant1_first_im,
    output logic signed [SAMPLE_BITS-1:0] ant1_second_re,
    output logic signed [SAMPLE_BITS-1:0] ant1_second_im,
    output logic signed [SAMPLE_BITS-1:0] ant2_first_re,
    output logic signed [SAMPLE_BITS-1:0] ant2_first_im,
    output logic signed [SAMPLE_BITS-1:0] ant2_second_re,
    output logic signed [SAMPLE_BITS-1:0] ant2_second_im
);

    localparam int SB = SAMPLE_BITS;
    localparam int SW = SB + 4;
    localparam int PW = SB + COEF_W;
    localparam logic signed [SW-1:0] SAT_HI = {{(SW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-SB+1){1'b1}}, {(SB-1){1'b0}}};
    localparam logic signed [PW-1:0] COEF  = PW'(SQRT2_Q14);
    localparam logic signed [PW-1:0] RND   = PW'(ROUND_HALF);

    function automatic logic signed [SW-1:0] ext(input logic signed [SB-1:0] v);
        return SW'(v);
    endfunction

    // floor((v * sqrt2 + half) / 2^14)
    function automatic logic signed [SW-1:0] scale(input logic signed [SB-1:0] v);
        logic signed [PW-1:0] prod;
        logic signed [PW-1:0] sum;
        prod = PW'(v) * COEF;
        sum  = prod + RND;
        return SW'($signed(sum[PW-1:SCALE_SHIFT]));
    endfunction

    function automatic logic signed [SB-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        else
        begin
            c = v;
        end
        return c[SB-1:0];
    endfunction

    logic signed [SW-1:0] r0_s;
    logic signed [SW-1:0] i0_s;
    logic signed [SW-1:0] r1_s;
    logic signed [SW-1:0] i1_s;

    always_comb
    begin
        if (pilot)
        begin
            r0_s = scale(first_re);
            i0_s = scale(first_im);
            r1_s = scale(second_re);
            i1_s = scale(second_im);
        end
        else
        begin
            r0_s = ext(first_re);
            i0_s = ext(first_im);
            r1_s = ext(second_re);
            i1_s = ext(second_im);
        end

        ant1_first_re  = sat(r0_s);
        ant1_first_im  = sat(i0_s);
        ant1_second_re = sat(-r1_s);
        ant1_second_im = sat(i1_s);

        if (pilot)
        begin
            ant2_first_re  = '0;
            ant2_first_im  = '0;
            ant2_second_re = '0;
            ant2_second_im = '0;
        end
        else
        begin
            ant2_first_re  = second_re;
            ant2_first_im  = second_im;
            ant2_second_re = first_re;
            ant2_second_im = sat(-ext(first_im));
        end
    end

endmodule

// ===== sv/alamouti_sfbc_pilot_encoder.sv =====
// Top level of the 2x1 Alamouti SFBC encoder with pilot pairs.
//
// Input channel (in_valid/in_ready) carries one word per subcarrier pair:
// even subcarrier first_re/first_im and odd subcarrier second_re/second_im.
// Output channel (out_valid/out_ready) carries one word per pair: both
// antenna pairs plus is_pilot and last_pair flags.
// Config channel (cfg_valid/cfg_ready, always ready) writes pairs_per_symbol
// (index 0), pilot_mask_low (1) and pilot_mask_high (2); write only when idle.
// Two register stages: input register, then the mapping/saturation logic
// into the output register. An accepted word passes from the input
// register into the output register and leaves from there when out_ready is high;
// throughput is one pair per cycle while out_ready stays high.
// Pilot and last flags are looked up from the pair counter at input accept.
// Reset clears the valid flags of both stages, the pair counter, the masks and sets
// pairs_per_symbol to 32.
// When out_ready is low the output word holds; the input register still
// fills, so one more word is taken before in_ready drops.
module alamouti_sfbc_pilot_encoder import sfbc_pkg::*; #(
    parameter int MAX_PAIRS   = 128,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] first_re,
    input  logic signed [SAMPLE_BITS-1:0] first_im,
    input  logic signed [SAMPLE_BITS-1:0] second_re,
    input  logic signed [SAMPLE_BITS-1:0] second_im,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] ant1_first_re,
    output logic signed [SAMPLE_BITS-1:0] ant1_first_im,
    output logic signed [SAMPLE_BITS-1:0] ant1_second_re,
    output logic signed [SAMPLE_BITS-1:0] ant1_second_im,
    output logic signed [SAMPLE_BITS-1:0] ant2_first_re,
    output logic signed [SAMPLE_BITS-1:0] ant2_first_im,
    output logic signed [SAMPLE_BITS-1:0] ant2_second_re,
    output logic signed [SAMPLE_BITS-1:0] ant2_second_im,
    output logic                          is_pilot,
    output logic                          last_pair
);

    localparam int SB = SAMPLE_BITS;

    pair_flags_t          flags;
    pair_flags_t          s1_flags_reg;
    logic                 s1_valid_reg;
    logic signed [SB-1:0] s1_r0_reg;
    logic signed [SB-1:0] s1_i0_reg;
    logic signed [SB-1:0] s1_r1_reg;
    logic signed [SB-1:0] s1_i1_reg;
    logic                 in_acc;
    logic                 out_load;

    logic signed [SB-1:0] e_a1r0;
    logic signed [SB-1:0] e_a1i0;
    logic signed [SB-1:0] e_a1r1;
    logic signed [SB-1:0] e_a1i1;
    logic signed [SB-1:0] e_a2r0;
    logic signed [SB-1:0] e_a2i0;
    logic signed [SB-1:0] e_a2r1;
    logic signed [SB-1:0] e_a2i1;

    logic                 out_valid_reg;
    logic signed [SB-1:0] a1r0_reg;
    logic signed [SB-1:0] a1i0_reg;
    logic signed [SB-1:0] a1r1_reg;
    logic signed [SB-1:0] a1i1_reg;
    logic signed [SB-1:0] a2r0_reg;
    logic signed [SB-1:0] a2i0_reg;
    logic signed [SB-1:0] a2r1_reg;
    logic signed [SB-1:0] a2i1_reg;
    pair_flags_t          out_flags_reg;

    assign cfg_ready = 1'b1;
    assign out_load  = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || out_load;
    assign in_acc    = in_valid && in_ready;

    sfbc_ctrl #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (in_acc),
        .flags     (flags)
    );

    sfbc_encode #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_encode (
        .first_re       (s1_r0_reg),
        .first_im       (s1_i0_reg),
        .second_re      (s1_r1_reg),
        .second_im      (s1_i1_reg),
        .pilot          (s1_flags_reg.pilot),
        .ant1_first_re  (e_a1r0),
        .ant1_first_im  (e_a1i0),
        .ant1_second_re (e_a1r1),
        .ant1_second_im (e_a1i1),
        .ant2_first_re  (e_a2r0),
        .ant2_first_im  (e_a2i0),
        .ant2_second_re (e_a2r1),
        .ant2_second_im (e_a2i1)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_r0_reg    <= first_re;
            s1_i0_reg    <= first_im;
            s1_r1_reg    <= second_re;
            s1_i1_reg    <= second_im;
            s1_flags_reg <= flags;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            a1r0_reg      <= e_a1r0;
            a1i0_reg      <= e_a1i0;
            a1r1_reg      <= e_a1r1;
            a1i1_reg      <= e_a1i1;
            a2r0_reg      <= e_a2r0;
            a2i0_reg      <= e_a2i0;
            a2r1_reg      <= e_a2r1;
            a2i1_reg      <= e_a2i1;
            out_flags_reg <= s1_flags_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign ant1_first_re  = a1r0_reg;
    assign ant1_first_im  = a1i0_reg;
    assign ant1_second_re = a1r1_reg;
    assign ant1_second_im = a1i1_reg;
    assign ant2_first_re  = a2r0_reg;
    assign ant2_first_im  = a2i0_reg;
    assign ant2_second_re = a2r1_reg;
    assign ant2_second_im = a2i1_reg;
    assign is_pilot       = out_flags_reg.pilot;
    assign last_pair      = out_flags_reg.last;

endmodule
